/* rtl/core/mws_pkg.sv */
// Shared constants, codes, item types and sequencer states of the moving-window statistics block.
package mws_pkg;

    // Field and total widths
    localparam int SAMPLE_BITS    = 24;
    localparam int VALUE_BITS     = 32;
    localparam int STATUS_BITS    = 2;
    localparam int SUM_BITS       = 32;
    localparam int SQ_BITS        = 56;
    localparam int COUNT_BITS     = 9;
    localparam int MODE_BITS      = 3;
    localparam int WSIZE_BITS     = 9;
    localparam int MUL_BITS       = 32;
    localparam int WIDE_BITS      = 64;
    localparam int STEP_BITS      = 6;
    localparam int DIV_STEPS      = 64;
    localparam int SQRT_STEPS     = 32;
    localparam int APB_ADDR_BITS  = 3;
    localparam int APB_DATA_BITS  = 32;
    localparam int MAX_WINDOW_DEF = 256;

    // Operating modes
    localparam logic [MODE_BITS-1:0] MODE_SUM  = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_AVG  = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_DIFF = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_SSTD = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_PSTD = 3'd4;

    // Result status codes
    localparam logic [STATUS_BITS-1:0] STATUS_NONE    = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_OK      = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_INVALID = 2'd2;

    // Register indexes and byte addresses
    localparam logic REG_MODE   = 1'b0;
    localparam logic REG_WINDOW = 1'b1;
    localparam logic [APB_ADDR_BITS-1:0] ADDR_MODE   = 3'd0;
    localparam logic [APB_ADDR_BITS-1:0] ADDR_WINDOW = 3'd4;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   sample_valid;
        logic                   first_of_series;
    } item_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0]  value;
        logic [STATUS_BITS-1:0] status;
    } result_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_OLD_RD,
        S_OLD_MUL,
        S_OLD_SUB,
        S_NEW_ADD,
        S_DIFF,
        S_DISPATCH,
        S_NQ_LO,
        S_NQ_HI,
        S_NM,
        S_D,
        S_DIV,
        S_SQRT_INIT,
        S_SQRT,
        S_SQRT_FIN,
        S_AVG_FIN,
        S_DONE
    } state_t;

endpackage

/* rtl/core/moving_window_statistics.sv */
// Moving-window sum, average, difference and deviation over a sample stream, one shared unit.
//
//  channel   direction  handshake                    payload
//  -------   ---------  ---------------------------  -----------------------------
//  item      in         item_valid / item_ready      sample, sample_valid, first_of_series
//  result    out        result_valid / result_ready  value, status
//  apb       in/out     psel, penable, pwrite        paddr, pwdata, prdata, pready
//
//  The average runs the 64-step shift-subtract divide and either deviation adds the
//  32-step square root; both run one bit a cycle through the single 64-bit subtractor,
//  and a single 32x32 multiplier forms every product in turn. item_ready is high only
//  while the sequencer is idle.
//  A finished result waits in the output register; the next item may be taken meanwhile.
//  Reset clears totals and pointers at once; the sample store needs no clearing pass.
module moving_window_statistics #(
    parameter int MAX_WINDOW = mws_pkg::MAX_WINDOW_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mws_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [mws_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [mws_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                pready,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  mws_pkg::item_t                      item,
    output logic                                result_valid,
    input  logic                                result_ready,
    output mws_pkg::result_t                    result
);

    localparam int AW = $clog2(MAX_WINDOW);
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int SB = mws_pkg::SAMPLE_BITS;
    localparam int WB = mws_pkg::WIDE_BITS;
    localparam int MB = mws_pkg::MUL_BITS;
    localparam int NB = mws_pkg::COUNT_BITS;
    localparam logic [CW:0]   MAX_W     = (CW+1)'(MAX_WINDOW);
    localparam logic [CW-1:0] MAX_POS   = CW'(MAX_WINDOW);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_WINDOW - 1);
    localparam logic [WB-1:0] SQRT_ONE  = 64'h4000_0000_0000_0000;
    localparam logic [WB-1:0] VALUE_MAX = 64'h0000_0000_7FFF_FFFF;

    // Configuration registers
    logic [mws_pkg::MODE_BITS-1:0]  mode_reg;
    logic [mws_pkg::WSIZE_BITS-1:0] wsize_reg;

    // Sequencer and control
    mws_pkg::state_t state_reg, state_next;
    logic            out_valid_reg;
    mws_pkg::result_t out_reg;

    // Running totals and pointers
    logic [mws_pkg::SUM_BITS-1:0] sum_reg;
    logic [mws_pkg::SQ_BITS-1:0]  sq_reg;
    logic [NB-1:0]                cnt_reg;
    logic [CW-1:0]                pos_reg;
    logic [AW-1:0]                wp_reg;

    // Item and working registers
    logic [SB-1:0]    x_reg;
    logic             xv_reg;
    logic [CW-1:0]    w_reg;
    logic [SB:0]      old_reg;
    logic [31:0]      diff_reg;
    logic             diff_ok_reg;
    logic [WB-1:0]    mul_reg;
    logic [WB-1:0]    acc_reg;
    logic [WB-1:0]    quo_reg;
    logic [WB-1:0]    res_reg;
    logic [WB-1:0]    one_reg;
    logic [WB-1:0]    den_reg;
    logic [WB-1:0]    s2_reg;
    logic [WB-1:0]    lo_reg;
    logic [mws_pkg::STEP_BITS-1:0] step_reg;
    logic [31:0]      val_reg;
    logic [mws_pkg::STATUS_BITS-1:0] stat_reg;

    // Sample store
    logic [SB:0]   mem [MAX_WINDOW];
    logic [SB:0]   mem_rd_reg;
    logic [AW-1:0] rd_addr;
    logic          mem_we;

    // Shared unit operands
    logic [MB-1:0] mul_a, mul_b;
    logic [WB-1:0] sub_a, sub_b;
    logic [WB:0]   sub_full;
    logic          sub_borrow;
    logic [WB-1:0] sub_diff;

    // Derived values
    logic [31:0]   ws_ext;
    logic [CW-1:0] w_now;
    logic [SB-1:0] x_mag, rd_mag;
    logic [31:0]   x_ext, rd_ext, old_ext;
    logic          s_neg;
    logic [31:0]   sum_mag;
    logic          std_ok;
    logic [NB-1:0] m_val;
    logic [CW:0]   old_t, old_full, diff_t, diff_full;
    logic [AW-1:0] old_idx, diff_idx;
    logic          old_hit, diff_ok_now;
    logic [WB-1:0] rem_shift;
    logic [32:0]   nq_mid;
    logic          nq_sat;
    logic [WB-1:0] nq;
    logic [WB-1:0] sqrt_round;
    logic          accept;

    // Configuration port
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= '0;
            wsize_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[2])
                mws_pkg::REG_MODE:   mode_reg  <= pwdata[mws_pkg::MODE_BITS-1:0];
                mws_pkg::REG_WINDOW: wsize_reg <= pwdata[mws_pkg::WSIZE_BITS-1:0];
                default:             mode_reg  <= mode_reg;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == mws_pkg::ADDR_MODE)
            prdata = 32'(mode_reg);
        else if (paddr == mws_pkg::ADDR_WINDOW)
            prdata = 32'(wsize_reg);
    end

    // Clamp the window to the store depth
    assign ws_ext = 32'(wsize_reg);
    assign w_now  = (ws_ext > 32'(MAX_WINDOW)) ? MAX_POS : ws_ext[CW-1:0];

    // Magnitudes and sign extensions
    assign x_mag   = x_reg[SB-1] ? SB'(~x_reg + SB'(1)) : x_reg;
    assign rd_mag  = mem_rd_reg[SB-1] ? SB'(~mem_rd_reg[SB-1:0] + SB'(1)) : mem_rd_reg[SB-1:0];
    assign x_ext   = {{(32-SB){x_reg[SB-1]}}, x_reg};
    assign rd_ext  = {{(32-SB){mem_rd_reg[SB-1]}}, mem_rd_reg[SB-1:0]};
    assign old_ext = {{(32-SB){old_reg[SB-1]}}, old_reg[SB-1:0]};
    assign s_neg   = sum_reg[31];
    assign sum_mag = s_neg ? (~sum_reg + 32'd1) : sum_reg;
    assign std_ok  = (mode_reg == mws_pkg::MODE_SSTD) ? (cnt_reg >= NB'(2)) : (cnt_reg != '0);
    assign m_val   = (mode_reg == mws_pkg::MODE_SSTD) ? (cnt_reg - NB'(1)) : cnt_reg;

    // Store addresses: the leaving sample and the one window_size-1 back
    assign old_t     = (CW+1)'(wp_reg) - (CW+1)'(w_reg);
    assign old_full  = old_t[CW] ? (old_t + MAX_W) : old_t;
    assign old_idx   = old_full[AW-1:0];
    assign diff_t    = (CW+1)'(wp_reg) - (CW+1)'(w_reg) + (CW+1)'(1);
    assign diff_full = diff_t[CW] ? (diff_t + MAX_W) : diff_t;
    assign diff_idx  = diff_full[AW-1:0];
    assign old_hit   = (w_reg != '0) && (pos_reg >= w_reg);
    assign diff_ok_now = (w_reg != '0) && xv_reg
                         && (((CW+1)'(pos_reg) + (CW+1)'(1)) >= (CW+1)'(w_reg));

    // Shared subtractor
    assign rem_shift  = {acc_reg[WB-2:0], quo_reg[WB-1]};
    assign sub_full   = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_borrow = sub_full[WB];
    assign sub_diff   = sub_full[WB-1:0];

    // Assemble n*Q from its two partial products, saturating
    assign nq_mid = {1'b0, lo_reg[63:32]} + {1'b0, mul_reg[31:0]};
    assign nq_sat = (mul_reg[63:32] != '0) || nq_mid[32];
    assign nq     = nq_sat ? '1 : {nq_mid[31:0], lo_reg[31:0]};

    assign sqrt_round = sub_borrow ? (res_reg + 64'd1) : res_reg;
    assign accept     = item_valid && item_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mws_pkg::S_IDLE:      if (item_valid) state_next = mws_pkg::S_OLD_RD;
            mws_pkg::S_OLD_RD:    state_next = mws_pkg::S_OLD_MUL;
            mws_pkg::S_OLD_MUL:   state_next = mws_pkg::S_OLD_SUB;
            mws_pkg::S_OLD_SUB:   state_next = mws_pkg::S_NEW_ADD;
            mws_pkg::S_NEW_ADD:   state_next = mws_pkg::S_DIFF;
            mws_pkg::S_DIFF:      state_next = mws_pkg::S_DISPATCH;
            mws_pkg::S_DISPATCH:
            begin
                state_next = mws_pkg::S_DONE;
                if (w_reg != '0)
                begin
                    if (mode_reg == mws_pkg::MODE_AVG && cnt_reg != '0)
                        state_next = mws_pkg::S_DIV;
                    else if ((mode_reg == mws_pkg::MODE_SSTD || mode_reg == mws_pkg::MODE_PSTD)
                             && std_ok)
                        state_next = mws_pkg::S_NQ_LO;
                end
            end
            mws_pkg::S_NQ_LO:     state_next = mws_pkg::S_NQ_HI;
            mws_pkg::S_NQ_HI:     state_next = mws_pkg::S_NM;
            mws_pkg::S_NM:        state_next = mws_pkg::S_D;
            mws_pkg::S_D:         state_next = mws_pkg::S_DIV;
            mws_pkg::S_DIV:
            begin
                if (step_reg == mws_pkg::STEP_BITS'(mws_pkg::DIV_STEPS - 1))
                    state_next = (mode_reg == mws_pkg::MODE_AVG) ? mws_pkg::S_AVG_FIN
                                                                 : mws_pkg::S_SQRT_INIT;
            end
            mws_pkg::S_SQRT_INIT: state_next = mws_pkg::S_SQRT;
            mws_pkg::S_SQRT:
            begin
                if (step_reg == mws_pkg::STEP_BITS'(mws_pkg::SQRT_STEPS - 1))
                    state_next = mws_pkg::S_SQRT_FIN;
            end
            mws_pkg::S_SQRT_FIN:  state_next = mws_pkg::S_DONE;
            mws_pkg::S_AVG_FIN:   state_next = mws_pkg::S_DONE;
            mws_pkg::S_DONE:      if (!out_valid_reg || result_ready) state_next = mws_pkg::S_IDLE;
            default:              state_next = mws_pkg::S_IDLE;
        endcase
    end

    // Operand selection and store control
    always_comb
    begin
        mul_a   = '0;
        mul_b   = '0;
        sub_a   = rem_shift;
        sub_b   = den_reg;
        rd_addr = old_idx;
        mem_we  = 1'b0;
        unique case (state_reg)
            mws_pkg::S_OLD_MUL:
            begin
                mul_a = MB'(rd_mag);
                mul_b = MB'(rd_mag);
            end
            mws_pkg::S_OLD_SUB:
            begin
                mul_a = MB'(x_mag);
                mul_b = MB'(x_mag);
            end
            mws_pkg::S_NEW_ADD:
            begin
                rd_addr = diff_idx;
                mem_we  = 1'b1;
            end
            mws_pkg::S_DISPATCH:
            begin
                mul_a = sum_mag;
                mul_b = sum_mag;
            end
            mws_pkg::S_NQ_LO:
            begin
                mul_a = sq_reg[31:0];
                mul_b = MB'(cnt_reg);
            end
            mws_pkg::S_NQ_HI:
            begin
                mul_a = MB'(sq_reg[mws_pkg::SQ_BITS-1:32]);
                mul_b = MB'(cnt_reg);
            end
            mws_pkg::S_NM:
            begin
                mul_a = MB'(cnt_reg);
                mul_b = MB'(m_val);
            end
            mws_pkg::S_D:
            begin
                sub_a = acc_reg;
                sub_b = s2_reg;
            end
            mws_pkg::S_SQRT:
            begin
                sub_a = acc_reg;
                sub_b = res_reg + one_reg;
            end
            mws_pkg::S_SQRT_FIN:
            begin
                sub_a = res_reg;
                sub_b = acc_reg;
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    // Sample store: one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wp_reg] <= {xv_reg, x_reg};
        mem_rd_reg <= mem[rd_addr];
    end

    // Control state, totals and pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mws_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            sum_reg       <= '0;
            sq_reg        <= '0;
            cnt_reg       <= '0;
            pos_reg       <= '0;
            wp_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;

            // Hold the result until taken
            if (state_reg == mws_pkg::S_DONE && (!out_valid_reg || result_ready))
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;

            // Drop the series at its first item
            if (accept && item.first_of_series)
            begin
                sum_reg <= '0;
                sq_reg  <= '0;
                cnt_reg <= '0;
                pos_reg <= '0;
                wp_reg  <= '0;
            end

            // Retire the sample leaving the window
            if (state_reg == mws_pkg::S_OLD_SUB && old_hit && old_reg[SB])
            begin
                sum_reg <= sum_reg - old_ext;
                sq_reg  <= sq_reg - mul_reg[mws_pkg::SQ_BITS-1:0];
                cnt_reg <= cnt_reg - NB'(1);
            end

            // Add the new sample
            if (state_reg == mws_pkg::S_NEW_ADD && w_reg != '0 && xv_reg)
            begin
                sum_reg <= sum_reg + x_ext;
                sq_reg  <= sq_reg + mul_reg[mws_pkg::SQ_BITS-1:0];
                cnt_reg <= cnt_reg + NB'(1);
            end

            // Advance the pointers
            if (state_reg == mws_pkg::S_DIFF)
            begin
                wp_reg <= (wp_reg == LAST_ADDR) ? '0 : (wp_reg + AW'(1));
                if (pos_reg < MAX_POS)
                    pos_reg <= pos_reg + CW'(1);
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        mul_reg <= {32'b0, mul_a} * {32'b0, mul_b};

        unique case (state_reg)
            mws_pkg::S_IDLE:
            begin
                x_reg  <= item.sample;
                xv_reg <= item.sample_valid;
                w_reg  <= w_now;
            end
            mws_pkg::S_OLD_MUL:
            begin
                old_reg <= mem_rd_reg;
            end
            mws_pkg::S_DIFF:
            begin
                diff_reg    <= (w_reg == CW'(1)) ? 32'd0 : (x_ext - rd_ext);
                diff_ok_reg <= diff_ok_now;
            end
            mws_pkg::S_DISPATCH:
            begin
                val_reg  <= '0;
                stat_reg <= mws_pkg::STATUS_NONE;
                if (w_reg != '0)
                begin
                    unique case (mode_reg)
                        mws_pkg::MODE_SUM:
                        begin
                            if (cnt_reg != '0)
                            begin
                                val_reg  <= sum_reg;
                                stat_reg <= mws_pkg::STATUS_OK;
                            end
                        end
                        mws_pkg::MODE_AVG:
                        begin
                            quo_reg  <= WB'({sum_mag, 1'b0}) + WB'(cnt_reg);
                            acc_reg  <= '0;
                            den_reg  <= WB'({cnt_reg, 1'b0});
                            step_reg <= '0;
                        end
                        mws_pkg::MODE_DIFF:
                        begin
                            if (diff_ok_reg)
                            begin
                                val_reg  <= diff_reg;
                                stat_reg <= mws_pkg::STATUS_OK;
                            end
                        end
                        mws_pkg::MODE_SSTD, mws_pkg::MODE_PSTD:
                        begin
                            if (!std_ok)
                                stat_reg <= mws_pkg::STATUS_INVALID;
                        end
                        default:
                        begin
                            stat_reg <= mws_pkg::STATUS_NONE;
                        end
                    endcase
                end
            end
            mws_pkg::S_NQ_LO:
            begin
                s2_reg <= mul_reg;
            end
            mws_pkg::S_NQ_HI:
            begin
                lo_reg <= mul_reg;
            end
            mws_pkg::S_NM:
            begin
                acc_reg <= nq;
            end
            mws_pkg::S_D:
            begin
                // Clip a negative spread to zero, then divide by n*m
                quo_reg  <= sub_borrow ? '0 : sub_diff;
                acc_reg  <= '0;
                den_reg  <= mul_reg;
                step_reg <= '0;
            end
            mws_pkg::S_DIV:
            begin
                acc_reg  <= sub_borrow ? rem_shift : sub_diff;
                quo_reg  <= {quo_reg[WB-2:0], ~sub_borrow};
                step_reg <= step_reg + mws_pkg::STEP_BITS'(1);
            end
            mws_pkg::S_SQRT_INIT:
            begin
                acc_reg  <= quo_reg;
                res_reg  <= '0;
                one_reg  <= SQRT_ONE;
                step_reg <= '0;
            end
            mws_pkg::S_SQRT:
            begin
                if (!sub_borrow)
                begin
                    acc_reg <= sub_diff;
                    res_reg <= (res_reg >> 1) + one_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                one_reg  <= one_reg >> 2;
                step_reg <= step_reg + mws_pkg::STEP_BITS'(1);
            end
            mws_pkg::S_SQRT_FIN:
            begin
                val_reg  <= (sqrt_round > VALUE_MAX) ? VALUE_MAX[31:0] : sqrt_round[31:0];
                stat_reg <= mws_pkg::STATUS_OK;
            end
            mws_pkg::S_AVG_FIN:
            begin
                val_reg  <= s_neg ? (~quo_reg[31:0] + 32'd1) : quo_reg[31:0];
                stat_reg <= mws_pkg::STATUS_OK;
            end
            mws_pkg::S_DONE:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_reg.value  <= val_reg;
                    out_reg.status <= stat_reg;
                end
            end
            default:
            begin
                step_reg <= step_reg;
            end
        endcase
    end

    assign item_ready   = (state_reg == mws_pkg::S_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Checks
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= MAX_POS)
        else $error("position count above store depth");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !item_ready)
        else $error("item taken while another is in work");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mws_pkg::S_DIV) |-> (den_reg != '0))
        else $error("divide by zero in shared unit");

    a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wp_reg <= LAST_ADDR)
        else $error("write pointer outside store");

endmodule
